// ===== hdl/tkd_pkg.sv =====
// Package for the trie key dictionary: shared types, codes and the symbol mapping.
`default_nettype none
package tkd_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Character bytes index a table of this size; anything at or above it is invalid.
  localparam int CHAR_TABLE_SIZE = 128;

  // Raw symbol index returned for a byte outside the identifier alphabet.
  localparam logic [6:0] SYM_NONE = 7'd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // clearing pass active
    logic accept;   // an input transfer completes this cycle
    logic resolve;  // resolve the child link read for the held item
    logic finish;   // produce the result of a finished key
  } tkd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;  // final entry of the clearing pass is written this cycle
    logic last;        // the held item ends its key
    logic out_free;    // the result register can take a new result
  } tkd_status_t;

  // Position of a byte in the sorted alphabet 0-9, A-Z, _, a-z, or SYM_NONE.
  function automatic logic [6:0] sym_raw(input logic [6:0] c);
    logic [6:0] r;
    r = SYM_NONE;
    if (c >= 7'd48 && c <= 7'd57) begin
      r = c - 7'd48;
    end else if (c >= 7'd65 && c <= 7'd90) begin
      r = c - 7'd55;
    end else if (c == 7'd95) begin
      r = 7'd36;
    end else if (c >= 7'd97 && c <= 7'd122) begin
      r = c - 7'd60;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/trie_key_dictionary.sv =====
// Top level of the trie key dictionary: stream ports, controller and datapath.
`default_nettype none
// Keys arrive one character per input transfer, with tlast on the final transfer of a key
// and tuser carrying the operation (insert, lookup or remove) and a flag that says whether
// the transfer holds a character at all; a key made only of transfers without a character
// addresses the root. Each key gives exactly one output transfer, after its last input
// transfer: success, the stored value on a successful lookup, a pool-full flag for an insert
// that ran out of nodes, and the number of nodes in use. Nodes are allocated from a pool of
// NODE_POOL entries that is never freed. After reset the block runs a clearing pass over the
// child-link and present memories, one entry per cycle, over NODE_POOL times the next power of
// two at or above ALPHABET_SIZE entries (65536 with the default settings), and s_tready stays
// low throughout. From then on, in the cycle of an item's transfer the child link of the
// current node is read from the single-port link memory, and in the next cycle the link is
// followed or a node is allocated; for an item with tlast the present mark and value of the
// final node are read in that same cycle, and a finish state then produces the result, waiting
// only while the previous result still sits unread in the output register.
module trie_key_dictionary
  import tkd_pkg::*;
#(
  parameter int NODE_POOL     = 1024,
  parameter int ALPHABET_SIZE = 63,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // char_code [7:0], new_value [39:8]
  input  wire logic        s_tlast,
  input  wire logic [2:0]  s_tuser,   // operation [1:0], has_char [2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // stored_value [31:0], nodes_in_use [42:32], zeros above
  output logic [1:0]       m_tuser    // success [0], pool_full [1]
);

  tkd_cmd_t    cmd;
  tkd_status_t status;

  logic        res_success;
  logic [31:0] res_value;
  logic        res_pool;
  logic [10:0] res_nodes;

  // The controller sequences clearing, per-character walk steps and result delivery.
  tkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the trie memories, the walk cursor and the output register.
  tkd_datapath #(
    .NODE_POOL     (NODE_POOL),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .VALUE_BITS    (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (s_tuser[1:0]),
    .in_has_char      (s_tuser[2]),
    .in_char_code     (s_tdata[7:0]),
    .in_last          (s_tlast),
    .in_new_value     (s_tdata[39:8]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_success      (res_success),
    .out_stored_value (res_value),
    .out_pool_full    (res_pool),
    .out_nodes_in_use (res_nodes)
  );

  assign m_tdata = {5'd0, res_nodes, res_value};
  assign m_tuser = {res_pool, res_success};

endmodule
`default_nettype wire

// ===== hdl/tkd_ctrl.sv =====
// Controller state machine of the trie key dictionary.
`default_nettype none
module tkd_ctrl
  import tkd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  tkd_status_t      status,
  output tkd_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t state;

  always_comb begin
    cmd.clear   = (state == ST_CLEAR);
    cmd.accept  = in_valid && in_ready;
    cmd.resolve = (state == ST_CHECK);
    cmd.finish  = (state == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (status.clear_done) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_CHECK;
            in_ready <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (status.last) begin
            state <= ST_FINISH;
          end else begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        ST_FINISH: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tkd_datapath.sv =====
// Datapath of the trie key dictionary: link, present and value memories, walk state, result register.
`default_nettype none
module tkd_datapath
  import tkd_pkg::*;
#(
  parameter int NODE_POOL     = 1024,
  parameter int ALPHABET_SIZE = 63,
  parameter int VALUE_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  tkd_cmd_t         cmd,
  output tkd_status_t      status,
  input  wire logic [1:0]  in_operation,
  input  wire logic        in_has_char,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last,
  input  wire logic [31:0] in_new_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_success,
  output logic [31:0]      out_stored_value,
  output logic             out_pool_full,
  output logic [10:0]      out_nodes_in_use
);

  localparam int NW = $clog2(NODE_POOL);
  localparam int IW = $clog2(ALPHABET_SIZE);
  localparam int AW = NW + IW;
  localparam int CW = $clog2(NODE_POOL + 1);
  localparam int CLEAR_LAST = NODE_POOL * (2 ** IW) - 1;

  typedef enum logic [1:0] {
    MODE_WALK,
    MODE_FAIL,
    MODE_POOL
  } mode_t;

  logic [NW-1:0]         link_mem    [2**AW];
  logic                  present_mem [2**NW];
  logic [VALUE_BITS-1:0] value_mem   [2**NW];

  logic [NW-1:0]         link_q;
  logic                  present_q;
  logic [VALUE_BITS-1:0] value_q;

  logic [AW-1:0]         clear_cnt;
  logic [NW-1:0]         cursor, cursor_next;
  logic [CW-1:0]         alloc_count, alloc_count_next;
  mode_t                 mode, mode_next;

  // Held item.
  logic [1:0]            op_q;
  logic                  has_q;
  logic                  idx_ok_q;
  logic [IW-1:0]         idx_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [6:0]            raw_in;
  logic                  idx_ok_in;
  logic                  alloc;
  logic                  finish_go;
  logic                  link_we;
  logic [AW-1:0]         link_wa;
  logic [NW-1:0]         link_wd;
  logic                  pres_we;
  logic [NW-1:0]         pres_wa;
  logic                  pres_wd;
  logic                  value_we;
  logic                  pv_rd;
  logic                  res_success;
  logic [31:0]           res_value;
  logic                  res_pool;

  assign raw_in    = sym_raw(in_char_code[6:0]);
  assign idx_ok_in = !in_char_code[7] && (raw_in != SYM_NONE) &&
                     (raw_in < 7'(ALPHABET_SIZE));

  assign status.clear_done = cmd.clear && (clear_cnt == AW'(CLEAR_LAST));
  assign status.last       = last_q;
  assign status.out_free   = !out_valid || out_ready;
  assign finish_go         = cmd.finish && status.out_free;

  // Walk step for the held character.
  always_comb begin
    cursor_next      = cursor;
    mode_next        = mode;
    alloc_count_next = alloc_count;
    alloc            = 1'b0;
    if (cmd.resolve && has_q && mode == MODE_WALK) begin
      priority if (!idx_ok_q) begin
        mode_next = MODE_FAIL;
      end else if (link_q != '0) begin
        cursor_next = link_q;
      end else if (op_q != OP_INSERT) begin
        mode_next = MODE_FAIL;
      end else if (alloc_count >= CW'(NODE_POOL)) begin
        mode_next = MODE_POOL;
      end else begin
        alloc            = 1'b1;
        cursor_next      = alloc_count[NW-1:0];
        alloc_count_next = alloc_count + CW'(1);
      end
    end
    if (finish_go) begin
      cursor_next = '0;
      mode_next   = MODE_WALK;
    end
  end

  // Result of a finished key, decided by the operation on its last item.
  always_comb begin
    res_success = 1'b0;
    res_value   = '0;
    res_pool    = 1'b0;
    unique case (op_q)
      OP_INSERT: begin
        res_success = (mode == MODE_WALK);
        res_pool    = (mode == MODE_POOL);
      end
      OP_LOOKUP: begin
        if (mode == MODE_WALK && present_q) begin
          res_success = 1'b1;
          res_value   = 32'(value_q);
        end
      end
      OP_REMOVE: begin
        res_success = (mode == MODE_WALK) && present_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    link_we = cmd.clear || alloc;
    link_wa = cmd.clear ? clear_cnt : {cursor, idx_q};
    link_wd = cmd.clear ? '0 : alloc_count[NW-1:0];

    pres_we = 1'b0;
    pres_wa = cursor;
    pres_wd = 1'b0;
    if (cmd.clear) begin
      pres_we = 1'b1;
      pres_wa = clear_cnt[AW-1:IW];
    end else if (finish_go && mode == MODE_WALK) begin
      if (op_q == OP_INSERT) begin
        pres_we = 1'b1;
        pres_wd = 1'b1;
      end else if (op_q == OP_REMOVE && present_q) begin
        pres_we = 1'b1;
      end
    end
    value_we = finish_go && mode == MODE_WALK && op_q == OP_INSERT;
    pv_rd    = cmd.resolve && last_q;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.accept) begin
      link_q <= link_mem[{cursor, raw_in[IW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      present_mem[pres_wa] <= pres_wd;
    end
    if (pv_rd) begin
      present_q <= present_mem[cursor_next];
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[cursor] <= val_q;
    end
    if (pv_rd) begin
      value_q <= value_mem[cursor_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= in_operation;
      has_q    <= in_has_char;
      idx_ok_q <= idx_ok_in;
      idx_q    <= raw_in[IW-1:0];
      last_q   <= in_last;
      val_q    <= VALUE_BITS'(in_new_value);
    end
    if (finish_go) begin
      out_success      <= res_success;
      out_stored_value <= res_value;
      out_pool_full    <= res_pool;
      out_nodes_in_use <= 11'(alloc_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt   <= '0;
      cursor      <= '0;
      alloc_count <= CW'(1);
      mode        <= MODE_WALK;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clear_cnt <= clear_cnt + AW'(1);
      end
      cursor      <= cursor_next;
      alloc_count <= alloc_count_next;
      mode        <= mode_next;
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the trie key dictionary with directed, random and pool-fill tests.
`default_nettype none
module tb_top;
  import tkd_pkg::*;

  localparam int NODES       = 1024;
  localparam int ALPHA_COUNT = 63;
  localparam int KEY_MAX     = 8;
  localparam int SAVED_KEYS  = 32;
  localparam int STALL_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 12;

  // Operation code 3 has no name in the package: it walks like a lookup and never succeeds.
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef enum logic [1:0] {
    WALK_OK,
    WALK_FAILED,
    WALK_NO_ROOM
  } walk_state_t;

  typedef struct packed {
    logic        success;
    logic [31:0] stored_value;
    logic        pool_full;
    logic [10:0] nodes_in_use;
  } dict_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // char_code [7:0], new_value [39:8]
  logic        s_tlast;
  logic [2:0]  s_tuser;   // operation [1:0], has_char [2]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // stored_value [31:0], nodes_in_use [42:32]
  logic [1:0]  m_tuser;   // success [0], pool_full [1]

  trie_key_dictionary dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the dictionary state.
  logic [7:0]  alpha_chars [ALPHA_COUNT];
  logic [6:0]  char_index [CHAR_TABLE_SIZE];
  logic [9:0]  trie_links [NODES][ALPHA_COUNT];
  logic        value_held [NODES];
  logic [31:0] node_value [NODES];
  int          node_total;
  logic [9:0]  cursor;
  walk_state_t walk;

  dict_result_t expected_results [$];

  // Keys that have been inserted, reused so that lookups and removes find something.
  logic [7:0] saved_key [SAVED_KEYS][KEY_MAX];
  int         saved_len [SAVED_KEYS];
  int         saved_count;

  int  errors;
  int  items_sent;
  int  results_seen;
  int  lookup_hits;
  int  pool_refusals;
  int  idle_cycles;
  int  stall_left;
  bit  send_idle;
  bit  stall_on;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_symbol(input bit narrow);
    return alpha_chars[narrow ? $urandom_range(0, 5) : $urandom_range(0, ALPHA_COUNT - 1)];
  endfunction

  // Advance the shadow trie by one accepted transfer and queue the result on the last one.
  task automatic predict_item(input logic [1:0] op, input logic has_chr, input logic [7:0] code,
                              input logic is_last, input logic [31:0] val);
    logic [6:0]   sym;
    logic [9:0]   nxt;
    dict_result_t r;
    if (has_chr && walk == WALK_OK) begin
      sym = code[7] ? 7'(ALPHA_COUNT) : char_index[code[6:0]];
      if (sym >= ALPHA_COUNT) begin
        walk = WALK_FAILED;
      end else begin
        nxt = trie_links[cursor][sym];
        if (nxt != '0) begin
          cursor = nxt;
        end else if (op != OP_INSERT) begin
          walk = WALK_FAILED;
        end else if (node_total >= NODES) begin
          walk = WALK_NO_ROOM;
        end else begin
          nxt = 10'(node_total);
          node_total++;
          trie_links[cursor][sym] = nxt;
          cursor = nxt;
        end
      end
    end
    if (is_last) begin
      r = '0;
      case (op)
        OP_INSERT: begin
          if (walk == WALK_OK) begin
            node_value[cursor] = val;
            value_held[cursor] = 1'b1;
            r.success = 1'b1;
          end else if (walk == WALK_NO_ROOM) begin
            r.pool_full = 1'b1;
            pool_refusals++;
          end
        end
        OP_LOOKUP: begin
          if (walk == WALK_OK && value_held[cursor]) begin
            r.success = 1'b1;
            r.stored_value = node_value[cursor];
            lookup_hits++;
          end
        end
        OP_REMOVE: begin
          if (walk == WALK_OK && value_held[cursor]) begin
            value_held[cursor] = 1'b0;
            r.success = 1'b1;
          end
        end
        default: ;
      endcase
      r.nodes_in_use = 11'(node_total);
      expected_results.insert(expected_results.size(), r);
      cursor = '0;
      walk = WALK_OK;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [1:0] op, input logic has_chr, input logic [7:0] code,
                           input logic is_last, input logic [31:0] val);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, code};
    s_tlast  <= is_last;
    s_tuser  <= {has_chr, op};
    do @(posedge clk); while (!s_tready);
    predict_item(op, has_chr, code, is_last, val);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [1:0] op, input string word, input logic [31:0] val);
    if (word.len() == 0) begin
      send_item(op, 1'b0, 8'($urandom), 1'b1, val);
    end else begin
      for (int i = 0; i < word.len(); i++) send_item(op, 1'b1, word[i], i == word.len() - 1, val);
    end
  endtask

  // Occasionally slips in a transfer without a character, which must change nothing.
  task automatic send_key(input logic [1:0] op, input logic [7:0] chars [KEY_MAX],
                          input int len, input logic [31:0] val);
    if (len == 0) begin
      send_item(op, 1'b0, 8'($urandom), 1'b1, val);
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) send_item(op, 1'b0, 8'($urandom), 1'b0, $urandom);
        send_item(op, 1'b1, chars[i], i == len - 1, val);
      end
    end
  endtask

  task automatic test_empty_key;
    send_word(OP_LOOKUP, "", 32'h0);
    send_word(OP_INSERT, "", 32'hA5A5_5A5A);
    send_word(OP_LOOKUP, "", 32'h0);
    send_word(OP_REMOVE, "", 32'h0);
    send_word(OP_REMOVE, "", 32'h0);
    // A leading transfer without a character still addresses the key "Q".
    send_item(OP_INSERT, 1'b0, 8'h5A, 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, "Q", 1'b1, 32'h0000_0051);
  endtask

  task automatic test_alphabet_edges;
    send_word(OP_INSERT, "0", 32'h0000_0000);
    send_word(OP_INSERT, "z", 32'hFFFF_FFFF);
    send_word(OP_INSERT, "_9", 32'h8000_0001);
    send_word(OP_LOOKUP, "z", 32'h0);
    send_word(OP_LOOKUP, "0", 32'h0);
    send_word(OP_LOOKUP, "_9", 32'h0);
    send_word(OP_INSERT, "z", 32'h1234_5678);
    send_word(OP_LOOKUP, "z", 32'h0);
  endtask

  task automatic test_bad_characters;
    // The node for "A" is allocated before the bad byte and must stay allocated.
    send_item(OP_INSERT, 1'b1, "A", 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, 8'hFF, 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, "B", 1'b1, 32'h1);
    send_word(OP_LOOKUP, "A", 32'h0);
    send_item(OP_LOOKUP, 1'b1, 8'h2E, 1'b1, 32'h0);
    send_item(OP_INSERT, 1'b1, 8'h7F, 1'b1, 32'h2);
    send_item(OP_INSERT, 1'b1, 8'h80, 1'b1, 32'h3);
    send_word(OP_REMOVE, "Zq", 32'h0);
  endtask

  task automatic test_mixed_operations;
    // Insert allocates on the first character; the lookup on the last then misses.
    send_item(OP_INSERT, 1'b1, "m", 1'b0, 32'h0);
    send_item(OP_LOOKUP, 1'b1, "n", 1'b1, 32'h0);
    send_item(OP_INSERT, 1'b1, "m", 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, "n", 1'b1, 32'h0);
    send_word(OP_SPARE, "z", 32'hDEAD_BEEF);
    send_word(OP_REMOVE, "z", 32'h0);
    send_word(OP_LOOKUP, "z", 32'h0);
  endtask

  task automatic test_random_traffic(input int item_budget);
    int          start;
    int          len;
    int          slot;
    int          r;
    logic [1:0]  op;
    logic [7:0]  chars [KEY_MAX];
    bit          narrow;
    start = items_sent;
    while (items_sent - start < item_budget) begin
      if ($urandom_range(0, 29) == 0) send_idle = !send_idle;
      if ($urandom_range(0, 9) == 0) begin
        // Noise: any operation code, any byte, characters that may be missing.
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          send_item(2'($urandom), $urandom_range(0, 4) != 0, 8'($urandom), i == len - 1,
                    $urandom);
      end else begin
        if (saved_count > 0 && $urandom_range(0, 1) == 0) begin
          slot = $urandom_range(0, saved_count - 1);
          len = saved_len[slot];
          chars = saved_key[slot];
        end else begin
          narrow = $urandom_range(0, 9) < 6;
          len = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 6);
          for (int i = 0; i < KEY_MAX; i++) chars[i] = rand_symbol(narrow);
        end
        r = $urandom_range(0, 99);
        op = (r < 45) ? OP_INSERT : (r < 80) ? OP_LOOKUP : OP_REMOVE;
        send_key(op, chars, len, $urandom);
        if (op == OP_INSERT) begin
          if (saved_count < SAVED_KEYS) begin
            slot = saved_count;
            saved_count++;
          end else begin
            slot = $urandom_range(0, SAVED_KEYS - 1);
          end
          saved_key[slot] = chars;
          saved_len[slot] = len;
        end
      end
    end
  endtask

  // One long chain key runs the pool dry; later inserts that need a node must be refused.
  task automatic test_pool_exhaustion;
    int len;
    len = NODES - node_total + 6;
    for (int i = 0; i < len; i++)
      send_item(OP_INSERT, 1'b1, rand_symbol(1'b0), i == len - 1, $urandom);
    send_item(OP_INSERT, 1'b1, "y", 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, "_", 1'b0, 32'h0);
    send_item(OP_INSERT, 1'b1, "Y", 1'b1, 32'h0);
    // A bad byte on a full pool is an ordinary failure, not a pool failure.
    send_item(OP_INSERT, 1'b1, 8'hC1, 1'b1, 32'h0);
    send_word(OP_INSERT, "0", 32'h0BAD_F00D);
    send_word(OP_LOOKUP, "0", 32'h0);
  endtask

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_on = !stall_on;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = pick_gap(stall_on);
    end
  end

  always @(posedge clk) begin : check_results
    dict_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: tuser %b tdata %h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser[0] !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, m_tuser[0]);
          errors++;
        end
        if (m_tdata[31:0] !== want.stored_value) begin
          $error("stored_value: expected %h, got %h", want.stored_value, m_tdata[31:0]);
          errors++;
        end
        if (m_tuser[1] !== want.pool_full) begin
          $error("pool_full: expected %0d, got %0d", want.pool_full, m_tuser[1]);
          errors++;
        end
        if (m_tdata[42:32] !== want.nodes_in_use) begin
          $error("nodes_in_use: expected %0d, got %0d", want.nodes_in_use, m_tdata[42:32]);
          errors++;
        end
      end
    end
  end

  // The clearing pass after reset is the longest legitimate silence, well inside the limit.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transfer.", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    s_tuser = '0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    lookup_hits = 0;
    pool_refusals = 0;
    idle_cycles = 0;
    stall_left = 0;
    saved_count = 0;
    send_idle = 1'b0;
    stall_on = 1'b0;
    // Identifier alphabet in sorted order: digits, capitals, underscore, small letters.
    for (int i = 0; i < ALPHA_COUNT; i++) begin
      if (i < 10) alpha_chars[i] = "0" + 8'(i);
      else if (i < 36) alpha_chars[i] = "A" + 8'(i - 10);
      else if (i == 36) alpha_chars[i] = "_";
      else alpha_chars[i] = "a" + 8'(i - 37);
    end
    for (int i = 0; i < CHAR_TABLE_SIZE; i++) char_index[i] = 7'(ALPHA_COUNT);
    for (int i = 0; i < ALPHA_COUNT; i++) char_index[alpha_chars[i][6:0]] = 7'(i);
    for (int n = 0; n < NODES; n++) begin
      value_held[n] = 1'b0;
      node_value[n] = '0;
      for (int s = 0; s < ALPHA_COUNT; s++) trie_links[n][s] = '0;
    end
    node_total = 1;
    cursor = '0;
    walk = WALK_OK;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_key();
    test_alphabet_edges();
    send_idle = 1'b1;
    test_bad_characters();
    test_mixed_operations();
    test_random_traffic(600);
    test_pool_exhaustion();
    test_random_traffic(100);

    s_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("Sent %0d input transfers and checked %0d results; %0d lookups hit.",
             items_sent, results_seen, lookup_hits);
    $display("Nodes in use at the end: %0d, inserts refused for a full pool: %0d.",
             node_total, pool_refusals);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
